@@ src/dci_pkg.sv @@
// shared constants and types for the dependency closure install engine
package dci_pkg;

    localparam int unsigned NumPkgs  = 128;
    localparam int unsigned MaxEdges = 128;
    localparam int unsigned PkgW     = $clog2(NumPkgs);
    localparam int unsigned EdgeW    = $clog2(MaxEdges);
    localparam int unsigned CntW     = $clog2(MaxEdges + 1);
    localparam int unsigned ChgW     = 8;
    localparam int unsigned QDepth   = 4;
    localparam int unsigned QAw      = $clog2(QDepth);

    typedef enum logic [1:0] {
        KIND_CLEAR     = 2'd0,
        KIND_EDGE      = 2'd1,
        KIND_INSTALL   = 2'd2,
        KIND_UNINSTALL = 2'd3
    } t_kind;

    // one classified command from the front part to the back part
    typedef struct packed {
        t_kind           kind;
        logic [PkgW-1:0] pkg;
        logic [PkgW-1:0] dep;
    } t_cmd;

endpackage

@@ src/dci_front.sv @@
// front part: accepts words, classifies them and queues commands
module dci_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [1:0]    s_axis_tuser,  // kind[1:0]
    input  logic [15:0]   s_axis_tdata,  // package_req[6:0], dependency[13:7]
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output dci_pkg::t_cmd o_cmd
);

    dci_pkg::t_cmd              r_q [dci_pkg::QDepth];
    logic [dci_pkg::QAw-1:0]    r_wr;
    logic [dci_pkg::QAw-1:0]    r_rd;
    logic [dci_pkg::QAw:0]      r_cnt;
    dci_pkg::t_cmd              n_cmd;
    logic                       w_push;
    logic                       w_pop;

    // classify the incoming word
    always_comb begin
        n_cmd.kind = dci_pkg::t_kind'(s_axis_tuser);
        n_cmd.pkg  = s_axis_tdata[0 +: dci_pkg::PkgW];
        n_cmd.dep  = s_axis_tdata[dci_pkg::PkgW +: dci_pkg::PkgW];
    end

    assign s_axis_tready = (r_cnt != (dci_pkg::QAw+1)'(dci_pkg::QDepth));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_cnt != '0);
    assign w_pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd         = r_q[r_rd];

    // command queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

@@ src/dci_back.sv @@
// back part: edge stores, installed bits and breadth-first walk sequencer
module dci_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  dci_pkg::t_cmd i_cmd,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output logic [dci_pkg::ChgW-1:0] o_res
);

    localparam int unsigned AdjW = dci_pkg::PkgW + dci_pkg::EdgeW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EDGE_RD, ST_EDGE, ST_POP, ST_RDCNT, ST_LDCNT, ST_SCAN, ST_RDWAIT,
        ST_CHECK, ST_DONE
    } t_state;

    t_state                      r_state;
    logic [dci_pkg::PkgW-1:0]    r_fwd_mem [dci_pkg::NumPkgs*dci_pkg::MaxEdges];
    logic [dci_pkg::PkgW-1:0]    r_rev_mem [dci_pkg::NumPkgs*dci_pkg::MaxEdges];
    logic [dci_pkg::CntW-1:0]    r_fcnt_mem [dci_pkg::NumPkgs];
    logic [dci_pkg::CntW-1:0]    r_rcnt_mem [dci_pkg::NumPkgs];
    logic [dci_pkg::NumPkgs-1:0] r_fok;
    logic [dci_pkg::NumPkgs-1:0] r_rok;
    logic [dci_pkg::CntW-1:0]    r_fcnt_rd;
    logic [dci_pkg::CntW-1:0]    r_rcnt_rd;
    logic                        r_fok_rd;
    logic                        r_rok_rd;
    logic [dci_pkg::NumPkgs-1:0] r_inst;
    logic [dci_pkg::NumPkgs-1:0] r_mark;
    logic [dci_pkg::PkgW-1:0]    r_wq [dci_pkg::NumPkgs];
    logic [dci_pkg::PkgW:0]      r_head;
    logic [dci_pkg::PkgW:0]      r_tail;
    logic                        r_fwd;
    logic                        r_tgt;
    logic [dci_pkg::PkgW-1:0]    r_cur;
    logic [dci_pkg::CntW-1:0]    r_n;
    logic [dci_pkg::CntW-1:0]    r_k;
    logic [dci_pkg::PkgW-1:0]    r_rdata;
    logic [dci_pkg::PkgW-1:0]    r_qdata;
    logic [dci_pkg::PkgW:0]      r_chg;
    logic [dci_pkg::ChgW-1:0]    r_res;
    logic                        r_res_v;
    logic [dci_pkg::PkgW-1:0]    r_epkg;
    logic [dci_pkg::PkgW-1:0]    r_edep;
    logic [dci_pkg::PkgW-1:0]    w_faddr;
    logic [dci_pkg::PkgW-1:0]    w_raddr;
    logic [dci_pkg::CntW-1:0]    w_fcnt;
    logic [dci_pkg::CntW-1:0]    w_rcnt;

    assign o_cmd_ready = (r_state == ST_IDLE) && !r_res_v;
    assign o_res_valid = r_res_v;
    assign o_res       = r_res;

    // list length lookups: edge operands while loading, else the dequeued package
    assign w_faddr = (r_state == ST_EDGE_RD) ? r_epkg : r_qdata;
    assign w_raddr = (r_state == ST_EDGE_RD) ? r_edep : r_qdata;
    // an entry not written since the last clear reads as an empty list
    assign w_fcnt  = r_fok_rd ? r_fcnt_rd : '0;
    assign w_rcnt  = r_rok_rd ? r_rcnt_rd : '0;

    // edge and length memories, single read port each
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EDGE) begin
            if (w_fcnt < dci_pkg::CntW'(dci_pkg::MaxEdges)) begin
                r_fwd_mem[{r_epkg, w_fcnt[dci_pkg::EdgeW-1:0]}] <= r_edep;
                r_fcnt_mem[r_epkg] <= w_fcnt + 1'b1;
            end
            if (w_rcnt < dci_pkg::CntW'(dci_pkg::MaxEdges)) begin
                r_rev_mem[{r_edep, w_rcnt[dci_pkg::EdgeW-1:0]}] <= r_epkg;
                r_rcnt_mem[r_edep] <= w_rcnt + 1'b1;
            end
        end
        if (r_fwd)
            r_rdata <= r_fwd_mem[AdjW'({r_cur, r_k[dci_pkg::EdgeW-1:0]})];
        else
            r_rdata <= r_rev_mem[AdjW'({r_cur, r_k[dci_pkg::EdgeW-1:0]})];
        r_fcnt_rd <= r_fcnt_mem[w_faddr];
        r_rcnt_rd <= r_rcnt_mem[w_raddr];
        r_fok_rd  <= r_fok[w_faddr];
        r_rok_rd  <= r_rok[w_raddr];
    end

    // walk queue memory
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHECK && r_inst[r_rdata] != r_tgt && !r_mark[r_rdata]
                && r_tail < (dci_pkg::PkgW+1)'(dci_pkg::NumPkgs))
            r_wq[r_tail[dci_pkg::PkgW-1:0]] <= r_rdata;
        else if (r_state == ST_IDLE && i_cmd_valid && o_cmd_ready)
            r_wq[0] <= i_cmd.pkg;
        r_qdata <= r_wq[r_head[dci_pkg::PkgW-1:0]];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_inst  <= '0;
            r_mark  <= '0;
            r_res_v <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
            r_fok   <= '0;
            r_rok   <= '0;
        end else begin
            if (r_res_v && i_res_ready) r_res_v <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && o_cmd_ready) begin
                        case (i_cmd.kind)
                            dci_pkg::KIND_CLEAR: begin
                                r_inst <= '0;
                                r_fok  <= '0;
                                r_rok  <= '0;
                            end
                            dci_pkg::KIND_EDGE: begin
                                r_epkg  <= i_cmd.pkg;
                                r_edep  <= i_cmd.dep;
                                r_state <= ST_EDGE_RD;
                            end
                            default: begin
                                r_fwd <= (i_cmd.kind == dci_pkg::KIND_INSTALL);
                                r_tgt <= (i_cmd.kind == dci_pkg::KIND_INSTALL);
                                r_chg <= '0;
                                r_head <= '0;
                                if (r_inst[i_cmd.pkg] ==
                                        (i_cmd.kind == dci_pkg::KIND_INSTALL)) begin
                                    r_res   <= '0;
                                    r_res_v <= 1'b1;
                                end else begin
                                    r_tail <= (dci_pkg::PkgW+1)'(1);
                                    r_mark[i_cmd.pkg] <= 1'b1;
                                    r_state <= ST_POP;
                                end
                            end
                        endcase
                    end
                end
                ST_EDGE_RD: begin
                    // list lengths of both operands are read this cycle
                    r_state <= ST_EDGE;
                end
                ST_EDGE: begin
                    if (w_fcnt < dci_pkg::CntW'(dci_pkg::MaxEdges))
                        r_fok[r_epkg] <= 1'b1;
                    if (w_rcnt < dci_pkg::CntW'(dci_pkg::MaxEdges))
                        r_rok[r_edep] <= 1'b1;
                    r_state <= ST_IDLE;
                end
                ST_POP: begin
                    // queue read address settles on r_head this cycle
                    if (r_head == r_tail) r_state <= ST_DONE;
                    else r_state <= ST_RDCNT;
                end
                ST_RDCNT: begin
                    r_cur  <= r_qdata;
                    r_head <= r_head + 1'b1;
                    r_inst[r_qdata] <= r_tgt;
                    r_chg  <= r_chg + 1'b1;
                    r_k    <= '0;
                    r_state <= ST_LDCNT;
                end
                ST_LDCNT: begin
                    r_n     <= r_fwd ? w_fcnt : w_rcnt;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_k == r_n) r_state <= ST_POP;
                    else r_state <= ST_RDWAIT;
                end
                ST_RDWAIT: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (r_inst[r_rdata] != r_tgt && !r_mark[r_rdata]
                            && r_tail < (dci_pkg::PkgW+1)'(dci_pkg::NumPkgs)) begin
                        r_tail <= r_tail + 1'b1;
                        r_mark[r_rdata] <= 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                    r_state <= ST_SCAN;
                end
                ST_DONE: begin
                    r_mark  <= '0;
                    r_res   <= dci_pkg::ChgW'(r_chg);
                    r_res_v <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ src/dependency_closure_install_engine.sv @@
// top level of the dependency closure install engine
//  channel  | dir | tuser     | tdata (lsb first)
//  s_axis   | in  | kind[1:0] | package_req[6:0], dependency[13:7], zero[15:14]
//  m_axis   | out | -         | changed_count[7:0]
// clear words act on accept; edge words pass accept, length read and write
// a query already in its target state answers zero, no walk; others pass
// pop, count read, count load, scan per package; read wait, check per edge
// reset is synchronous active low and clears counts, bits and queues
// the back part takes no command while a result word waits on m_axis
// a four-entry command queue lets input run on while the back part stalls
module dependency_closure_install_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // kind
    input  logic [15:0] s_axis_tdata,  // package_req, dependency
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // changed_count
);

    dci_pkg::t_cmd w_cmd;
    logic          w_cmd_valid;
    logic          w_cmd_ready;

    dci_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    dci_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (m_axis_tdata)
    );

    // a result never exceeds the package count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata <= 8'(dci_pkg::NumPkgs))
        else $error("changed count out of range");

    // the back part takes no command while a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !w_cmd_ready)
        else $error("command taken with result pending");

endmodule
